// ----- rtl/pair_pool_allocator_with_sweep_macros.svh -----
// Assertion macros for the pair pool allocator.
`ifndef PAIR_POOL_ALLOCATOR_WITH_SWEEP_MACROS_SVH
`define PAIR_POOL_ALLOCATOR_WITH_SWEEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppa assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppa assertion failed: next-cycle check");

`endif

// ----- rtl/ppa_pkg.sv -----
// Shared types, codes and sizes for the pair pool allocator.
package ppa_pkg;

	localparam int POOL_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int IDX_W      = 10;
	localparam int LIVE_W     = 11;
	localparam int THR_W      = 16;
	localparam int SINCE_W    = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MARK  = 2'd2,
		OP_SWEEP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SWEEP,
		CS_EXEC
	} ctl_state_t;

	// Per-entry flag pair held in the flag memory
	typedef struct packed {
		logic free;
		logic mark;
	} flags_t;

	// Controller to datapath
	typedef struct packed {
		logic ready;
		logic sweep;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic take;
		logic take_sweep;
		logic sweep_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/ppa_if.sv -----
// Channel interfaces: request, response and configuration write.
interface ppa_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic [ppa_pkg::IDX_W-1:0] entry_index;

	modport source (output valid, output operation, output entry_index, input ready);
	modport sink   (input valid, input operation, input entry_index, output ready);
endinterface

interface ppa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ppa_pkg::IDX_W-1:0]  result_index;
	logic [1:0]                 status;
	logic [ppa_pkg::LIVE_W-1:0] live_count;
	logic                       need_collect;

	modport source (output valid, output result_index, output status, output live_count,
		output need_collect, input ready);
	modport sink   (input valid, input result_index, input status, input live_count,
		input need_collect, output ready);
endinterface

interface ppa_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ppa_pkg::THR_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ppa_datapath.sv -----
// Datapath: link and flag memories, pool counters, sweep walker and result register.
module ppa_datapath (
	input  logic              clk,
	input  logic              arst_n,
	ppa_req_if.sink           req,
	ppa_rsp_if.source         rsp,
	ppa_cfg_if.sink           cfg,
	input  ppa_pkg::ctl_cmd_t cmd,
	output ppa_pkg::dp_stat_t stat
);

	// Memories: free-list links and per-entry flags
	logic [ppa_pkg::ADDR_W-1:0] link_mem [ppa_pkg::POOL_DEPTH];
	ppa_pkg::flags_t            flag_mem [ppa_pkg::POOL_DEPTH];

	// Latched transaction and registered read data
	ppa_pkg::op_t               op_q;
	logic [ppa_pkg::IDX_W-1:0]  idx_q;
	ppa_pkg::flags_t            flag_rd_q;
	logic [ppa_pkg::ADDR_W-1:0] link_rd_q;

	// Pool state
	logic [ppa_pkg::CNT_W-1:0]   bump_q, bump_d;
	logic [ppa_pkg::CNT_W-1:0]   live_q, live_d;
	logic [ppa_pkg::SINCE_W-1:0] since_q, since_d;
	logic [ppa_pkg::ADDR_W-1:0]  head_q, head_d;
	logic                        nonempty_q, nonempty_d;
	logic [ppa_pkg::THR_W-1:0]   thr_q;

	// Sweep walker
	logic [ppa_pkg::CNT_W-1:0]  sweep_cnt_q;
	logic                       sweep_vld_s1;
	logic [ppa_pkg::ADDR_W-1:0] sweep_idx_s1;

	// Result register
	logic                       rsp_valid_q;
	logic [ppa_pkg::IDX_W-1:0]  rsp_idx_q;
	ppa_pkg::status_t           rsp_status_q;
	logic [ppa_pkg::LIVE_W-1:0] rsp_live_q;
	logic                       rsp_need_q;

	// Write ports and step results
	logic                       flag_we, link_we;
	logic [ppa_pkg::ADDR_W-1:0] flag_wa, link_wa, link_wd;
	ppa_pkg::flags_t            flag_wd;
	logic [ppa_pkg::IDX_W-1:0]  res_d;
	ppa_pkg::status_t           status_d;

	logic accept, sweep_issue, idx_hit, out_free;

	assign accept      = req.valid && cmd.ready;
	assign sweep_issue = cmd.sweep && (sweep_cnt_q < bump_q);
	assign idx_hit     = ppa_pkg::CNT_W'(idx_q) < bump_q;
	assign out_free    = !rsp_valid_q || rsp.ready;

	assign req.ready = cmd.ready;
	assign cfg.ready = 1'b1;

	assign stat.take       = accept;
	assign stat.take_sweep = accept && (ppa_pkg::op_t'(req.operation) == ppa_pkg::OP_SWEEP);
	assign stat.sweep_done = !(sweep_cnt_q < bump_q) && !sweep_vld_s1;
	assign stat.out_free   = out_free;

	// Memory reads (registered) and writes
	always_ff @(posedge clk) begin
		if (accept) begin
			flag_rd_q <= flag_mem[ppa_pkg::ADDR_W'(req.entry_index)];
			link_rd_q <= link_mem[head_q];
		end else if (sweep_issue) begin
			flag_rd_q <= flag_mem[sweep_cnt_q[ppa_pkg::ADDR_W-1:0]];
		end
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	// Next pool state: sweep entry retire, or commit of the latched transaction
	always_comb begin
		logic [ppa_pkg::ADDR_W-1:0] slot;
		logic                       ok;
		slot       = bump_q[ppa_pkg::ADDR_W-1:0];
		ok         = 1'b0;
		bump_d     = bump_q;
		live_d     = live_q;
		since_d    = since_q;
		head_d     = head_q;
		nonempty_d = nonempty_q;
		flag_we    = 1'b0;
		flag_wa    = ppa_pkg::ADDR_W'(idx_q);
		flag_wd    = flag_rd_q;
		link_we    = 1'b0;
		link_wa    = ppa_pkg::ADDR_W'(idx_q);
		link_wd    = head_q;
		res_d      = idx_q;
		status_d   = ppa_pkg::ST_DONE;
		if (sweep_vld_s1) begin
			// marked entries lose the mark, unmarked ones end up free
			flag_we      = 1'b1;
			flag_wa      = sweep_idx_s1;
			flag_wd.free = flag_rd_q.free | ~flag_rd_q.mark;
			flag_wd.mark = 1'b0;
			if (!flag_rd_q.mark && !flag_rd_q.free) begin
				link_we    = 1'b1;
				link_wa    = sweep_idx_s1;
				head_d     = sweep_idx_s1;
				nonempty_d = 1'b1;
				live_d     = live_q - 1'b1;
			end
		end else if (cmd.commit) begin
			case (op_q)
				ppa_pkg::OP_ALLOC: begin
					if (bump_q < ppa_pkg::CNT_W'(ppa_pkg::POOL_DEPTH)) begin
						slot   = bump_q[ppa_pkg::ADDR_W-1:0];
						bump_d = bump_q + 1'b1;
						ok     = 1'b1;
					end else if (nonempty_q) begin
						slot   = head_q;
						head_d = link_rd_q;
						ok     = 1'b1;
					end
					if (ok) begin
						flag_we = 1'b1;
						flag_wa = slot;
						flag_wd = '{free: 1'b0, mark: 1'b0};
						live_d  = live_q + 1'b1;
						since_d = (since_q != '1) ? since_q + 1'b1 : since_q;
						if (bump_d >= ppa_pkg::CNT_W'(ppa_pkg::POOL_DEPTH)) begin
							nonempty_d = live_d < bump_d;
						end
						res_d = ppa_pkg::IDX_W'(slot);
					end else begin
						res_d    = '0;
						status_d = ppa_pkg::ST_OOM;
					end
				end
				ppa_pkg::OP_FREE: begin
					if (idx_hit && !flag_rd_q.free) begin
						flag_we    = 1'b1;
						flag_wd    = '{free: 1'b1, mark: flag_rd_q.mark};
						link_we    = 1'b1;
						head_d     = ppa_pkg::ADDR_W'(idx_q);
						nonempty_d = 1'b1;
						live_d     = live_q - 1'b1;
					end else begin
						status_d = ppa_pkg::ST_IGNORED;
					end
				end
				ppa_pkg::OP_MARK: begin
					if (idx_hit && !flag_rd_q.mark) begin
						flag_we = 1'b1;
						flag_wd = '{free: flag_rd_q.free, mark: 1'b1};
					end else begin
						status_d = ppa_pkg::ST_IGNORED;
					end
				end
				ppa_pkg::OP_SWEEP: begin
					since_d = '0;
				end
				default: begin
					status_d = ppa_pkg::ST_DONE;
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q       <= '0;
			live_q       <= '0;
			since_q      <= '0;
			head_q       <= '0;
			nonempty_q   <= 1'b0;
			thr_q        <= ppa_pkg::THR_RESET;
			sweep_cnt_q  <= '0;
			sweep_vld_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			bump_q       <= bump_d;
			live_q       <= live_d;
			since_q      <= since_d;
			head_q       <= head_d;
			nonempty_q   <= nonempty_d;
			sweep_vld_s1 <= sweep_issue;
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (accept) begin
				sweep_cnt_q <= '0;
			end else if (sweep_issue) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ppa_pkg::op_t'(req.operation);
			idx_q <= req.entry_index;
		end
		sweep_idx_s1 <= sweep_cnt_q[ppa_pkg::ADDR_W-1:0];
		if (cmd.commit) begin
			rsp_idx_q    <= res_d;
			rsp_status_q <= status_d;
			rsp_live_q   <= ppa_pkg::LIVE_W'(live_d);
			rsp_need_q   <= since_d > thr_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_index = rsp_idx_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.live_count   = rsp_live_q;
	assign rsp.need_collect = rsp_need_q;

endmodule

// ----- rtl/ppa_ctrl.sv -----
// Controller: sequences accept, sweep walk and commit of each transaction.
module ppa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ppa_pkg::dp_stat_t stat,
	output ppa_pkg::ctl_cmd_t cmd
);

	ppa_pkg::ctl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppa_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppa_pkg::CS_IDLE: begin
				if (stat.take_sweep) begin
					state_d = ppa_pkg::CS_SWEEP;
				end else if (stat.take) begin
					state_d = ppa_pkg::CS_EXEC;
				end
			end
			ppa_pkg::CS_SWEEP: begin
				if (stat.sweep_done) begin
					state_d = ppa_pkg::CS_EXEC;
				end
			end
			ppa_pkg::CS_EXEC: begin
				if (stat.out_free) begin
					state_d = ppa_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = ppa_pkg::CS_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ppa_pkg::CS_IDLE:  cmd.ready  = 1'b1;
			ppa_pkg::CS_SWEEP: cmd.sweep  = 1'b1;
			ppa_pkg::CS_EXEC:  cmd.commit = stat.out_free;
			default:           cmd = '0;
		endcase
	end

endmodule

// ----- rtl/pair_pool_allocator_with_sweep.sv -----
// Top level of the pair pool allocator with free list and sweep.
//
// Channels: req carries one transaction (operation, entry_index); rsp returns one
// result per request (result_index, status, live_count, need_collect); cfg writes
// collect_threshold and is always ready.
// Allocate, free and mark: the accepting cycle reads the link and flag memories
// into registers; the commit, made once the result register is free, updates
// them and loads the result. A new request is taken only after the last commit.
// Sweep: after the accepting cycle the flag memory is walked one entry per cycle
// in ascending order over the entries handed out so far, the read of one entry
// overlapping the update of the previous one; then the last entry is retired,
// the walk is seen finished, and the result is loaded once the result register
// is free.
// One request is in work at a time; the result register lets the next request
// be accepted while a result still waits. If rsp stalls with a result held and
// another result is ready, the block holds that result until the register frees.
// Reset clears the counters, the free list and the result register, and loads
// collect_threshold with 1000. The flag memory needs no clearing: only entries
// below bump_index are ever acted on, and each is written when first handed out.
`include "pair_pool_allocator_with_sweep_macros.svh"

module pair_pool_allocator_with_sweep (
	input logic       clk,
	input logic       arst_n,
	ppa_req_if.sink   req,
	ppa_rsp_if.source rsp,
	ppa_cfg_if.sink   cfg
);

	ppa_pkg::ctl_cmd_t cmd;
	ppa_pkg::dp_stat_t stat;

	ppa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ppa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Checks
	`PPA_ASSERT_NEXT(a_one_in_work, clk, arst_n, req.valid && req.ready, !req.ready)
	`PPA_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, rsp.valid)
	`PPA_ASSERT_SAME(a_oom_zero, clk, arst_n, rsp.valid && (rsp.status == ppa_pkg::ST_OOM), rsp.result_index == '0)
	`PPA_ASSERT_SAME(a_live_bound, clk, arst_n, rsp.valid, rsp.live_count <= ppa_pkg::LIVE_W'(ppa_pkg::POOL_DEPTH))

endmodule
